@@ sv/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants of the life grid engine: pen command codes,
// register indexes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lge_pkg;

    // size limits of the grid
    localparam int LGE_MAX_COLUMNS = 64;
    localparam int LGE_MAX_ROWS    = 64;

    // field widths
    localparam int DIM_W        = 7;   // grid_width / grid_height registers
    localparam int GEN_W        = 16;  // generations register
    localparam int CMD_W        = 8;   // pen command byte
    localparam int ROW_NUM_W    = 6;   // row_number field, also row index in commands
    localparam int ROW_CELLS_W  = 64;  // row_cells field
    localparam int OUT_TDATA_W  = 72;  // row_number + row_cells, padded to bytes
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // reset values of the configuration registers
    localparam logic [DIM_W-1:0] GRID_DIM_RESET = DIM_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GENS   = 2'd2;

    // pen command bytes
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 8'h78;  // x
    localparam logic [CMD_W-1:0] CMD_UP     = 8'h77;  // w
    localparam logic [CMD_W-1:0] CMD_LEFT   = 8'h61;  // a
    localparam logic [CMD_W-1:0] CMD_DOWN   = 8'h73;  // s
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 8'h64;  // d

    // controller to datapath commands
    typedef struct packed {
        logic                 draw;        // apply the accepted pen command
        logic                 mark_wr;     // write back the marked pen row
        logic                 rd_en;       // sequencer read of the grid memory
        logic [ROW_NUM_W-1:0] rd_row;
        logic                 win_clear;   // clear the row window
        logic                 step;        // shift the row window
        logic                 dn_zero;     // row below lies outside the grid
        logic                 gen_wr;      // write a new generation row
        logic [ROW_NUM_W-1:0] wr_row;
        logic                 out_load;    // load the output register
        logic [ROW_NUM_W-1:0] out_row;
        logic                 out_final;
        logic                 grid_clear;  // kill all cells, reset the pen
    } t_lge_cmd;

    // datapath to controller status
    typedef struct packed {
        logic             mark_req;  // accepted command marks a cell
        logic             out_free;  // output register empty next cycle
        logic [DIM_W-1:0] eff_h;     // rows in use
        logic [GEN_W-1:0] gens;      // generations to run
    } t_lge_status;

endpackage

@@ sv/life_grid_engine.sv @@
// ----------------------------------------------------------------------------
// life_grid_engine
// Draws a starting grid from pen command bytes, then runs Conway B3/S23
// generations on a bounded grid and streams the grid out one row at a time.
//
//  channel   dir  signals                       contents
//  s_axis    in   tvalid tready tdata tlast     tdata[7:0] command, tlast end_of_drawing
//  m_axis    out  tvalid tready tdata tlast     tdata row_number/row_cells, tlast final_row
//  cfg       in   valid ready index data        0 grid_width, 1 grid_height, 2 generations
//
// A drawing command that marks a cell also passes a mark state that writes the
// row back (read-modify-write on the grid memory). The last command then runs G
// generations on H rows (one row read and one row written per cycle), then
// reads each row out in turn and loads it into the output register.
// Output stalls hold the row readout. No clearing pass after reset: row
// valid bits clear the grid. The config port is always ready.
// ----------------------------------------------------------------------------
module life_grid_engine #(
    parameter int MAX_COLUMNS = lge_pkg::LGE_MAX_COLUMNS,
    parameter int MAX_ROWS    = lge_pkg::LGE_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pen commands
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lge_pkg::CMD_W-1:0]       s_axis_tdata,   // [7:0] command
    input  logic                            s_axis_tlast,
    // grid rows
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] row_number, [69:6] row_cells
    output logic                            m_axis_tlast
);
    import lge_pkg::*;

    t_lge_cmd             cmd;
    t_lge_status          status;
    logic [ROW_NUM_W-1:0]   out_row;
    logic [ROW_CELLS_W-1:0] out_cells;

    assign o_cfg_ready = 1'b1;

    // sequencer
    lge_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // grid and pen datapath
    lge_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_row   (out_row),
        .o_out_cells (out_cells),
        .o_out_final (m_axis_tlast)
    );

    // pack the result transaction
    assign m_axis_tdata = {{(OUT_TDATA_W - ROW_CELLS_W - ROW_NUM_W){1'b0}}, out_cells, out_row};

    // a mark write always follows an accepted command
    a_mark_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mark_wr |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("mark write without a preceding command transaction");

    // the output register is never overwritten while it holds a row
    a_no_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !m_axis_tvalid)
        else $error("output row overwritten before it was taken");

    // no new command while a run or a mark is in progress
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mark_wr || cmd.gen_wr || cmd.out_load) |-> !s_axis_tready)
        else $error("command accepted while the grid is busy");

    // the grid is cleared only on the last emitted row
    a_clear_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.grid_clear |-> (cmd.out_load && cmd.out_final))
        else $error("grid cleared outside the last row load");

endmodule

@@ sv/lge_ctrl.sv @@
// ----------------------------------------------------------------------------
// lge_ctrl
// Sequencer of the life grid engine: takes drawing commands, sweeps the
// grid once per generation and reads the rows out for emission.
// ----------------------------------------------------------------------------
module lge_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  lge_pkg::t_lge_status i_status,
    output lge_pkg::t_lge_cmd    o_cmd
);
    import lge_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_GEN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state                r_state, n_state;
    logic                  r_last,  n_last;
    logic [DIM_W-1:0]      r_k,     n_k;
    logic [GEN_W-1:0]      r_gens,  n_gens;
    logic [ROW_NUM_W-1:0]  r_row,   n_row;

    logic                  accept;
    logic                  gen_end;
    logic                  emit_end;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign gen_end  = (r_k == i_status.eff_h + DIM_W'(1));
    assign emit_end = (DIM_W'(r_row) + DIM_W'(1) == i_status.eff_h);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_k     = r_k;
        n_gens  = r_gens;
        n_row   = r_row;
        o_cmd   = '0;
        o_in_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.draw = 1'b1;
                    n_last     = i_in_last;
                    if (i_status.mark_req) begin
                        n_state = S_MARK;
                    end else if (i_in_last) begin
                        n_k    = '0;
                        n_row  = '0;
                        n_gens = i_status.gens;
                        n_state = (i_status.gens != '0) ? S_GEN : S_EMIT_RD;
                    end
                end
            end
            S_MARK: begin
                o_cmd.mark_wr = 1'b1;
                if (r_last) begin
                    n_k    = '0;
                    n_row  = '0;
                    n_gens = i_status.gens;
                    n_state = (i_status.gens != '0) ? S_GEN : S_EMIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_GEN: begin
                // read row k, update the window with row k-1, write new row k-2
                o_cmd.rd_en     = (r_k < i_status.eff_h);
                o_cmd.rd_row    = r_k[ROW_NUM_W-1:0];
                o_cmd.win_clear = (r_k == '0);
                o_cmd.step      = (r_k != '0);
                o_cmd.dn_zero   = (r_k > i_status.eff_h);
                o_cmd.gen_wr    = (r_k >= DIM_W'(2));
                o_cmd.wr_row    = ROW_NUM_W'(r_k - DIM_W'(2));
                if (gen_end) begin
                    n_k = '0;
                    if (r_gens == GEN_W'(1)) begin
                        n_state = S_EMIT_RD;
                    end
                    n_gens = r_gens - GEN_W'(1);
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            S_EMIT_RD: begin
                if (i_status.out_free) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_row = r_row;
                    n_state      = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_row   = r_row;
                o_cmd.out_final = emit_end;
                if (emit_end) begin
                    o_cmd.grid_clear = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + ROW_NUM_W'(1);
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_k     <= '0;
            r_gens  <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_k     <= n_k;
            r_gens  <= n_gens;
            r_row   <= n_row;
        end
    end

endmodule

@@ sv/lge_datapath.sv @@
// ----------------------------------------------------------------------------
// lge_datapath
// Grid memory with row valid bits, pen position, configuration registers,
// the three-row window with the B3/S23 row update, and the output register.
// ----------------------------------------------------------------------------
module lge_datapath #(
    parameter int MAX_COLUMNS = lge_pkg::LGE_MAX_COLUMNS,
    parameter int MAX_ROWS    = lge_pkg::LGE_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pen command
    input  logic [lge_pkg::CMD_W-1:0]       i_command,
    // controller
    input  lge_pkg::t_lge_cmd               i_cmd,
    output lge_pkg::t_lge_status            o_status,
    // result register
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [lge_pkg::ROW_NUM_W-1:0]   o_out_row,
    output logic [lge_pkg::ROW_CELLS_W-1:0] o_out_cells,
    output logic                            o_out_final
);
    import lge_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_COLUMNS);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_ROWS);

    typedef logic [MAX_COLUMNS-1:0] t_row;

    // configuration registers
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [GEN_W-1:0] r_cfg_gens;
    logic [DIM_W-1:0] eff_w, eff_h;
    t_row             col_mask;

    // pen state
    logic [COL_W-1:0] r_pen_col, n_pen_col;
    logic [ROW_W-1:0] r_pen_row, n_pen_row;
    logic             r_pen_down, n_pen_down;
    logic             mark;
    logic             mark_req;
    logic [COL_W-1:0] r_mark_col;
    logic [ROW_W-1:0] r_mark_row;

    // grid memory
    t_row             mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_valid;
    t_row             r_mem_q;
    logic             r_q_valid;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    t_row             wr_data;
    t_row             rd_raw, rd_masked;

    // generation window
    t_row             r_win_up, r_win_mid;
    t_row             dn_in, new_row;

    // result register
    logic             r_out_valid;
    logic [ROW_NUM_W-1:0] r_out_row;
    t_row             r_out_cells;
    logic             r_out_final;

    // one B3/S23 step of a row from its neighbor rows, bit-parallel count
    function automatic t_row life_row(input t_row up, input t_row mid,
                                      input t_row dn, input t_row m);
        t_row planes [8];
        t_row s0, s1, s2, c0, c1, two, three;
        planes[0] = (up << 1) & m;
        planes[1] = up;
        planes[2] = up >> 1;
        planes[3] = (mid << 1) & m;
        planes[4] = mid >> 1;
        planes[5] = (dn << 1) & m;
        planes[6] = dn;
        planes[7] = dn >> 1;
        s0 = '0;
        s1 = '0;
        s2 = '0;
        for (int p = 0; p < 8; p++) begin
            c0 = s0 & planes[p];
            s0 = s0 ^ planes[p];
            c1 = s1 & c0;
            s1 = s1 ^ c0;
            s2 = s2 ^ c1;
        end
        two   = ~s0 & s1 & ~s2;
        three =  s0 & s1 & ~s2;
        return (three | (mid & two)) & m;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= GRID_DIM_RESET;
            r_cfg_h    <= GRID_DIM_RESET;
            r_cfg_gens <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_cfg_w    <= i_cfg_data[DIM_W-1:0];
                CFG_IDX_HEIGHT: r_cfg_h    <= i_cfg_data[DIM_W-1:0];
                CFG_IDX_GENS:   r_cfg_gens <= i_cfg_data[GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective grid size and column mask
    always_comb begin
        if (r_cfg_w == '0)          eff_w = DIM_W'(1);
        else if (r_cfg_w > MAX_W_D) eff_w = MAX_W_D;
        else                        eff_w = r_cfg_w;
        if (r_cfg_h == '0)          eff_h = DIM_W'(1);
        else if (r_cfg_h > MAX_H_D) eff_h = MAX_H_D;
        else                        eff_h = r_cfg_h;
        for (int j = 0; j < MAX_COLUMNS; j++) begin
            col_mask[j] = (DIM_W'(j) < eff_w);
        end
    end

    // pen command decode
    always_comb begin
        n_pen_col  = r_pen_col;
        n_pen_row  = r_pen_row;
        n_pen_down = r_pen_down;
        mark       = 1'b0;
        case (i_command)
            CMD_TOGGLE: begin
                n_pen_down = !r_pen_down;
                mark       = !r_pen_down;
            end
            CMD_UP: begin
                if (r_pen_row != '0) begin
                    n_pen_row = r_pen_row - ROW_W'(1);
                    mark      = r_pen_down;
                end
            end
            CMD_LEFT: begin
                if (r_pen_col != '0) begin
                    n_pen_col = r_pen_col - COL_W'(1);
                    mark      = r_pen_down;
                end
            end
            CMD_DOWN: begin
                if (DIM_W'(r_pen_row) + DIM_W'(1) < eff_h) begin
                    n_pen_row = r_pen_row + ROW_W'(1);
                    mark      = r_pen_down;
                end
            end
            CMD_RIGHT: begin
                if (DIM_W'(r_pen_col) + DIM_W'(1) < eff_w) begin
                    n_pen_col = r_pen_col + COL_W'(1);
                    mark      = r_pen_down;
                end
            end
            default: ;
        endcase
        // a pen left outside a shrunk grid marks nothing
        mark_req = mark && (DIM_W'(n_pen_col) < eff_w) && (DIM_W'(n_pen_row) < eff_h);
    end

    // pen registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_col  <= '0;
            r_pen_row  <= '0;
            r_pen_down <= 1'b0;
        end else if (i_cmd.grid_clear) begin
            r_pen_col  <= '0;
            r_pen_row  <= '0;
            r_pen_down <= 1'b0;
        end else if (i_cmd.draw) begin
            r_pen_col  <= n_pen_col;
            r_pen_row  <= n_pen_row;
            r_pen_down <= n_pen_down;
        end
    end

    // cell to mark on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_mark_col <= n_pen_col;
            r_mark_row <= n_pen_row;
        end
    end

    // memory port selection
    assign rd_en   = i_cmd.rd_en || (i_cmd.draw && mark_req);
    assign rd_addr = i_cmd.draw ? n_pen_row : i_cmd.rd_row[ROW_W-1:0];
    assign wr_en   = i_cmd.mark_wr || i_cmd.gen_wr;
    assign wr_addr = i_cmd.mark_wr ? r_mark_row : i_cmd.wr_row[ROW_W-1:0];
    assign wr_data = i_cmd.mark_wr ? (rd_raw | (t_row'(1) << r_mark_col)) : new_row;

    // grid memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // row valid bits: a row never written since the last clear reads as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_q_valid   <= 1'b0;
        end else begin
            if (i_cmd.grid_clear) begin
                r_row_valid <= '0;
            end else if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_q_valid <= r_row_valid[rd_addr];
            end
        end
    end

    assign rd_raw    = r_q_valid ? r_mem_q : '0;
    assign rd_masked = rd_raw & col_mask;

    // row window and next-generation row
    assign dn_in   = i_cmd.dn_zero ? '0 : rd_masked;
    assign new_row = life_row(r_win_up, r_win_mid, dn_in, col_mask);

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_clear) begin
            r_win_up  <= '0;
            r_win_mid <= '0;
        end else if (i_cmd.step) begin
            r_win_up  <= r_win_mid;
            r_win_mid <= dn_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row   <= i_cmd.out_row;
            r_out_cells <= rd_masked;
            r_out_final <= i_cmd.out_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_cells = ROW_CELLS_W'(r_out_cells);
    assign o_out_final = r_out_final;

    // status to the controller
    assign o_status.mark_req = mark_req;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.eff_h    = eff_h;
    assign o_status.gens     = r_cfg_gens;

endmodule

@@ tb/life_grid_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_engine_tb
// Drives pen command streams and register writes into the life grid engine.
// A local model of the pen, the grid and the B3/S23 update predicts every
// row bitmap, and each row the block emits is checked against it field by
// field. Directed drawings cover reset values, grid extremes, ignored bytes,
// a pen stranded outside a shrunk grid, a very long run and an output hold.
// Random drawings follow, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module life_grid_engine_tb;
    import lge_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_LIMIT     = 1000000; // longest run is 65535 generations
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 420;
    localparam int MAX_REPORTS    = 40;

    // index 3 is not a register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [ROW_NUM_W-1:0]   row_number;
        logic [ROW_CELLS_W-1:0] row_cells;
        logic                   final_row;
    } t_grid_row;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_COIN, READY_PATTERN} t_rx_mode;

    // dut ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CMD_W-1:0]       s_axis_tdata  = '0;  // [7:0] command
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [5:0] row_number, [69:6] row_cells
    logic                   m_axis_tlast;

    // grid model
    logic [DIM_W-1:0]       width_reg  = GRID_DIM_RESET;
    logic [DIM_W-1:0]       height_reg = GRID_DIM_RESET;
    logic [GEN_W-1:0]       gens_reg   = '0;
    logic [ROW_CELLS_W-1:0] cells [LGE_MAX_ROWS];
    int                     pen_col;
    int                     pen_row;
    bit                     pen_down;

    t_grid_row expected_rows[$];
    t_grid_row oldest_row;

    // bookkeeping
    int fail_count     = 0;
    int rows_checked   = 0;
    int items_accepted = 0;
    int drawings_sent  = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int stall_left     = 0;
    t_rx_mode stall_mode = READY_ALWAYS;

    life_grid_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // grid model
    // ------------------------------------------------------------------------

    // zero acts as one, anything above the array size acts as the maximum
    function automatic int clamp_dim(input logic [DIM_W-1:0] raw, input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic logic [ROW_CELLS_W-1:0] column_mask(input int w);
        if (w >= ROW_CELLS_W) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic void clear_drawing();
        foreach (cells[r]) cells[r] = '0;
        pen_col  = 0;
        pen_row  = 0;
        pen_down = 1'b0;
    endfunction

    // a pen outside the current grid leaves no mark
    function automatic void mark_pen(input int w, input int h);
        if (pen_col < w && pen_row < h) cells[pen_row][pen_col] = 1'b1;
    endfunction

    // next state of one row; neighbor counts kept as three bit planes,
    // a count of 8 wraps to 0 which neither births nor survives
    function automatic logic [ROW_CELLS_W-1:0] life_row_next(
        input logic [ROW_CELLS_W-1:0] up,
        input logic [ROW_CELLS_W-1:0] mid,
        input logic [ROW_CELLS_W-1:0] dn,
        input logic [ROW_CELLS_W-1:0] mask
    );
        logic [ROW_CELLS_W-1:0] nb [8];
        logic [ROW_CELLS_W-1:0] c0, c1, c2, carry0, carry1, two, three;
        nb[0] = (up << 1) & mask;
        nb[1] = up;
        nb[2] = up >> 1;
        nb[3] = (mid << 1) & mask;
        nb[4] = mid >> 1;
        nb[5] = (dn << 1) & mask;
        nb[6] = dn;
        nb[7] = dn >> 1;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        for (int i = 0; i < 8; i++) begin
            carry0 = c0 & nb[i];
            c0     = c0 ^ nb[i];
            carry1 = c1 & carry0;
            c1     = c1 ^ carry0;
            c2     = c2 ^ carry1;
        end
        two   = ~c0 & c1 & ~c2;
        three = c0 & c1 & ~c2;
        return (three | (mid & two)) & mask;
    endfunction

    // run the configured generations; stops early once the grid is stable
    function automatic void evolve_grid(input int h, input logic [ROW_CELLS_W-1:0] m);
        logic [ROW_CELLS_W-1:0] evolved [LGE_MAX_ROWS];
        logic [ROW_CELLS_W-1:0] up, dn;
        bit changed;
        int g, r;
        for (g = 0; g < int'(gens_reg); g++) begin
            changed = 1'b0;
            for (r = 0; r < LGE_MAX_ROWS; r++) begin
                if (r >= h) begin
                    evolved[r] = '0;
                end else begin
                    up = (r > 0) ? (cells[r-1] & m) : '0;
                    dn = (r + 1 < h) ? (cells[r+1] & m) : '0;
                    evolved[r] = life_row_next(up, cells[r] & m, dn, m);
                end
                if (evolved[r] != cells[r]) changed = 1'b1;
            end
            if (!changed) break;
            for (r = 0; r < LGE_MAX_ROWS; r++) cells[r] = evolved[r];
        end
    endfunction

    // apply one accepted command; the last one of a drawing queues the rows
    function automatic void track_command(input logic [CMD_W-1:0] cmd, input logic last);
        int w, h, r;
        logic [ROW_CELLS_W-1:0] m;
        t_grid_row row;
        w = clamp_dim(width_reg, LGE_MAX_COLUMNS);
        h = clamp_dim(height_reg, LGE_MAX_ROWS);
        m = column_mask(w);
        case (cmd)
            CMD_TOGGLE: begin
                pen_down = !pen_down;
                if (pen_down) mark_pen(w, h);
            end
            CMD_UP: if (pen_row > 0) begin
                pen_row--;
                if (pen_down) mark_pen(w, h);
            end
            CMD_LEFT: if (pen_col > 0) begin
                pen_col--;
                if (pen_down) mark_pen(w, h);
            end
            CMD_DOWN: if (pen_row + 1 < h) begin
                pen_row++;
                if (pen_down) mark_pen(w, h);
            end
            CMD_RIGHT: if (pen_col + 1 < w) begin
                pen_col++;
                if (pen_down) mark_pen(w, h);
            end
            default: ;
        endcase
        if (last) begin
            evolve_grid(h, m);
            for (r = 0; r < h; r++) begin
                row.row_number = ROW_NUM_W'(r);
                row.row_cells  = cells[r] & m;
                row.final_row  = (r + 1 == h);
                expected_rows.push_back(row);
            end
            clear_drawing();
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one command transaction; the sender runs in bursts with random gaps
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        items_accepted++;
        if (last) drawings_sent++;
        track_command(cmd, last);
    endtask

    // stop sending, let every queued row come out and the block go quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // one config transaction; the caller lowers valid after the last one
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IDX_WIDTH:  width_reg  = data[DIM_W-1:0];
            CFG_IDX_HEIGHT: height_reg = data[DIM_W-1:0];
            CFG_IDX_GENS:   gens_reg   = data;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] w_word,
                            input logic [CFG_DATA_W-1:0] h_word,
                            input logic [CFG_DATA_W-1:0] gens);
        settle_block();
        write_register(CFG_IDX_WIDTH, w_word);
        write_register(CFG_IDX_HEIGHT, h_word);
        write_register(CFG_IDX_GENS, gens);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly small grids, sometimes full size or out of range;
    // the upper data bits are random and must be dropped
    function automatic logic [CFG_DATA_W-1:0] random_dim_word();
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 19))
            0, 1:       word[DIM_W-1:0] = DIM_W'(64);
            2:          word[DIM_W-1:0] = DIM_W'(1);
            3:          word[DIM_W-1:0] = ($urandom_range(0, 1) == 0) ? DIM_W'(0)
                                          : DIM_W'($urandom_range(65, 127));
            4, 5, 6, 7: word[DIM_W-1:0] = DIM_W'($urandom_range(21, 63));
            default:    word[DIM_W-1:0] = DIM_W'($urandom_range(2, 20));
        endcase
        return word;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_gens();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return CFG_DATA_W'($urandom_range(0, 3));
            6, 7, 8:          return CFG_DATA_W'($urandom_range(4, 12));
            default:          return CFG_DATA_W'($urandom_range(13, 40));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: 64x64 grid, no generations, drawing comes back as drawn
    task automatic test_reset_defaults();
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b1);
    endtask

    // width 0 acts as 1, height 127 as 64, spare index ignored,
    // ignored bytes, moves blocked at the top, left and right edges
    task automatic test_extremes_and_noise();
        settle_block();
        write_register(CFG_IDX_SPARE, 16'hFFFF);
        write_register(CFG_IDX_WIDTH, 16'hFF80);
        write_register(CFG_IDX_HEIGHT, 16'h007F);
        write_register(CFG_IDX_GENS, 16'd1);
        i_cfg_valid <= 1'b0;
        send_command(8'h00, 1'b0);
        send_command(8'hFF, 1'b0);
        send_command(CMD_UP, 1'b0);
        send_command(CMD_LEFT, 1'b0);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_TOGGLE, 1'b1);
    endtask

    // pen left outside after the grid shrinks: no marks, right/down blocked,
    // left/up still step back in
    task automatic test_pen_off_grid();
        set_grid(16'd8, 16'd8, 16'd0);
        send_command(CMD_TOGGLE, 1'b0);
        repeat (4) send_command(CMD_RIGHT, 1'b0);
        repeat (3) send_command(CMD_DOWN, 1'b0);
        set_grid(16'd3, 16'd3, 16'd1);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_LEFT, 1'b0);
        send_command(CMD_UP, 1'b0);
        send_command(CMD_LEFT, 1'b0);
        send_command(CMD_UP, 1'b1);
    endtask

    // maximum generation count on a still-life block, two rows tall
    task automatic test_long_still_life();
        set_grid(16'd64, 16'd2, 16'hFFFF);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_LEFT, 1'b1);
    endtask

    // receiver holds off while two drawings are offered, then a full drain
    task automatic test_output_backpressure();
        set_grid(16'd12, 16'd12, 16'd2);
        hold_asked++;
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_RIGHT, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_LEFT, 1'b0);
        send_command(CMD_LEFT, 1'b0);
        send_command(CMD_TOGGLE, 1'b1);
        send_command(CMD_TOGGLE, 1'b0);
        send_command(CMD_DOWN, 1'b0);
        send_command(CMD_RIGHT, 1'b1);
        settle_block();
    endtask

    // random drawings: mostly pen walks with some stray bytes, a few
    // drawings of pure noise, sizes changed between and inside drawings
    task automatic test_random_drawings();
        int len, i, pick;
        logic [CMD_W-1:0] cmd;
        while (items_accepted < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 6) set_grid(random_dim_word(), random_dim_word(),
                                                   random_gens());
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                    send_command(CMD_W'($urandom_range(0, 255)), i == len - 1);
            end else begin
                len = $urandom_range(1, 40);
                for (i = 0; i < len; i++) begin
                    if (i == len / 2 && $urandom_range(0, 9) == 0)
                        set_grid(random_dim_word(), random_dim_word(), random_gens());
                    pick = $urandom_range(0, 19);
                    case (pick)
                        0, 1:           cmd = CMD_W'($urandom_range(0, 255));
                        2, 3, 4, 19:    cmd = CMD_TOGGLE;
                        5, 6, 7, 8:     cmd = CMD_RIGHT;
                        9, 10, 11, 12:  cmd = CMD_DOWN;
                        13, 14, 15:     cmd = CMD_LEFT;
                        default:        cmd = CMD_UP;
                    endcase
                    send_command(cmd, i == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver stalls: changing patterns, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            case (stall_mode)
                READY_ALWAYS:  m_axis_tready <= 1'b1;
                READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                READY_COIN:    m_axis_tready <= ($urandom_range(0, 1) == 1);
                default:       m_axis_tready <= ((stall_left % 7) >= 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // row checker
    // ------------------------------------------------------------------------
    task automatic flag_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %h, got %h", field, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("row transaction %h with no row pending", m_axis_tdata);
            end else begin
                oldest_row = expected_rows.pop_front();
                if (m_axis_tdata[ROW_NUM_W-1:0] != oldest_row.row_number)
                    flag_field("row_number", 64'(oldest_row.row_number),
                               64'(m_axis_tdata[ROW_NUM_W-1:0]));
                if (m_axis_tdata[ROW_NUM_W +: ROW_CELLS_W] != oldest_row.row_cells)
                    flag_field("row_cells", oldest_row.row_cells,
                               m_axis_tdata[ROW_NUM_W +: ROW_CELLS_W]);
                if (m_axis_tlast !== oldest_row.final_row)
                    flag_field("final_row", 64'(oldest_row.final_row), 64'(m_axis_tlast));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("life_grid_engine: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_drawing();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes_and_noise();
        test_pen_off_grid();
        test_long_still_life();
        test_output_backpressure();
        test_random_drawings();

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands in %0d drawings sent, %0d rows compared",
                 items_accepted, drawings_sent, rows_checked);
        $display("grid sizes from one column to 64x64, up to 65535 generations, stalls both sides");
        if (fail_count == 0 && expected_rows.size() == 0) begin
            $display("life_grid_engine: match");
        end else begin
            $display("life_grid_engine: mismatch");
        end
        $finish;
    end

endmodule
